### design/grr_pkg.sv
package grr_pkg;

  localparam int GS_W = 7;
  localparam logic [GS_W-1:0] GS_RESET = 7'd1;

  typedef struct packed {
    logic wr;
    logic rd;
  } grr_cmd_t;

  typedef struct packed {
    logic emit;
    logic last;
  } grr_sts_t;

endpackage

### design/grr_if.sv
interface grr_in_if #(
  parameter int WORD_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] word;
  logic                  is_final;

  modport source (output valid, output word, output is_final, input ready);
  modport sink   (input valid, input word, input is_final, output ready);
endinterface

interface grr_out_if #(
  parameter int WORD_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] word_res;
  logic                  run_end;
  logic                  sequence_end;

  modport source (output valid, output word_res, output run_end, output sequence_end,
                  input ready);
  modport sink   (input valid, input word_res, input run_end, input sequence_end,
                  output ready);
endinterface

### design/grr_datapath.sv
module grr_datapath
  import grr_pkg::*;
#(
  parameter int MAX_GROUP  = 64,
  parameter int WORD_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [GS_W-1:0]       cfg_data,
  input  logic [WORD_WIDTH-1:0] in_word,
  input  logic                  in_is_final,
  input  grr_cmd_t              cmd,
  output grr_sts_t              sts,
  output logic [WORD_WIDTH-1:0] out_word_res,
  output logic                  out_run_end,
  output logic                  out_sequence_end
);

  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic [WORD_WIDTH-1:0] mem [0:MAX_GROUP-1];
  logic [WORD_WIDTH-1:0] rd_data_r;

  logic [GS_W-1:0] gs_r;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   cnt_r, pos_r;
  logic            rev_r, fin_r, last_r;

  logic [GS_W-1:0] k_eff;
  logic [CW-1:0]   base, n, rd_off;
  logic            full;

  // group size: zero acts as one, large values clip to the store depth
  always_comb begin
    k_eff = gs_r;
    if (gs_r == '0) k_eff = GS_W'(1);
    if (gs_r > GS_W'(MAX_GROUP)) k_eff = GS_W'(MAX_GROUP);
  end

  assign base     = (fill_r >= CW'(MAX_GROUP)) ? '0 : fill_r;
  assign n        = base + CW'(1);
  assign full     = (GS_W'(n) >= k_eff);
  assign sts.emit = full || in_is_final;
  assign sts.last = last_r;
  assign fill_nxt = sts.emit ? '0 : n;
  assign rd_off   = rev_r ? (cnt_r - CW'(1) - pos_r) : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r   <= GS_RESET;
      fill_r <= '0;
    end else begin
      if (cfg_we) gs_r <= cfg_data;
      if (cmd.wr) fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[base[AW-1:0]] <= in_word;
      cnt_r <= n;
      rev_r <= full;
      fin_r <= in_is_final;
      pos_r <= '0;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_off[AW-1:0]];
      last_r    <= (pos_r == cnt_r - CW'(1));
      pos_r     <= pos_r + CW'(1);
    end
  end

  assign out_word_res     = rd_data_r;
  assign out_run_end      = last_r;
  assign out_sequence_end = last_r && fin_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < CW'(MAX_GROUP) || fill_r == CW'(MAX_GROUP))
    else $error("fill count beyond store depth");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr && sts.emit |=> fill_r == '0)
    else $error("fill count not cleared after group release");

  a_no_wr_rd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr && cmd.rd))
    else $error("store written and read in one cycle");

endmodule

### design/grr_ctrl.sv
module grr_ctrl
  import grr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output grr_cmd_t cmd,
  input  grr_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SHOW = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr = 1'b1;
          if (sts.emit) state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last) state_nxt = ST_IDLE;
          else cmd.rd = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  a_read_then_show: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_SHOW)
    else $error("read not followed by result");

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state not one-hot");

  a_show_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHOW && !out_ready |=> state_r == ST_SHOW)
    else $error("stalled result dropped");

endmodule

### design/group_reversal_reorder_unit.sv
// Run start: an item that closes a group (or carries is_final) leads to ST_READ, which
//   loads the result register, then to ST_SHOW, which shows its first result; the rest
//   of the run follows at one result per cycle while the sink takes each result. An item
//   that only fills the store keeps the input open; a run holds it shut until its end.
// Reset (rst_n, synchronous, active low): fill count cleared, group size set to 1,
//   controller idle; the group store itself is not cleared.
module group_reversal_reorder_unit
  import grr_pkg::*;
#(
  parameter int MAX_GROUP  = 64,
  parameter int WORD_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [GS_W-1:0] cfg_data,
  grr_in_if.sink          in_ch,
  grr_out_if.source       out_ch
);

  grr_cmd_t cmd;
  grr_sts_t sts;

  // Controller: accepts an item only when no run is pending, then walks the run
  // one store read at a time, advancing on each taken result.
  grr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: group store, fill count, group size register and the read
  // sequencing (reversed for a full group, arrival order for a short tail).
  grr_datapath #(
    .MAX_GROUP  (MAX_GROUP),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_word          (in_ch.word),
    .in_is_final      (in_ch.is_final),
    .cmd              (cmd),
    .sts              (sts),
    .out_word_res     (out_ch.word_res),
    .out_run_end      (out_ch.run_end),
    .out_sequence_end (out_ch.sequence_end)
  );

  // one item in flight: no new item while a result is pending
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_ch.valid && in_ch.ready))
    else $error("input open while results pending");

  // a run drains without gaps once the sink takes items
  a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.run_end |=> out_ch.valid)
    else $error("gap inside a run");

  // the final word always releases the held words
  a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.is_final |=> !in_ch.ready)
    else $error("final item did not start a run");

endmodule
